### sv/paiws_pkg.sv
// Shared types and constants for the pedal ADC IIR window statistics block.
// Holds field widths, register indexes, reset coefficients and the sequencer states.
// No dependencies.
package paiws_pkg;

  localparam int DATA_W     = 16;
  localparam int CHAN_IN_W  = 3;
  localparam int MASK_W     = 8;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int COEF_W     = 16;
  localparam int COEF_N     = 5;
  localparam int PROD_W     = COEF_W + DATA_W + 1;
  localparam int Q_SHIFT    = 15;
  localparam int ACC_W      = 21;
  localparam int RESET_BASE = 2047;

  localparam logic [CFG_IDX_W-1:0] CFG_MASK = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_B0   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_B1   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_B2   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_A1   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_A2   = 3'd5;

  localparam logic signed [COEF_W-1:0] B0_RST = 16'sd6554;
  localparam logic signed [COEF_W-1:0] B1_RST = 16'sd13107;
  localparam logic signed [COEF_W-1:0] B2_RST = 16'sd6554;
  localparam logic signed [COEF_W-1:0] A1_RST = 16'sd0;
  localparam logic signed [COEF_W-1:0] A2_RST = 16'sd6554;

  typedef enum logic [6:0] {
    ST_CLEAR = 7'b0000001,
    ST_IDLE  = 7'b0000010,
    ST_READ  = 7'b0000100,
    ST_MAC   = 7'b0001000,
    ST_WRITE = 7'b0010000,
    ST_SCAN  = 7'b0100000,
    ST_DONE  = 7'b1000000
  } state_e;

endpackage

### sv/paiws_ram.sv
// Generic single-write, single-read synchronous RAM with a registered read port.
// Used for the raw and filtered sample rings. No dependencies.
module paiws_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 128
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### sv/paiws_div.sv
// Division by a fixed divisor through multiplication with its rounded-up reciprocal.
// Produces the registered window average from the window sum after start. No dependencies.
module paiws_div #(
  parameter int NUM_W   = 20,
  parameter int DIVISOR = 16,
  parameter int QUO_W   = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [NUM_W-1:0] dividend_i,
  output logic             done_o,
  output logic [QUO_W-1:0] quotient_o
);

  localparam int SHIFT  = NUM_W + $clog2(DIVISOR);
  localparam int MUL_W  = NUM_W + 2;
  localparam int PROD_W = NUM_W + MUL_W;
  localparam logic [MUL_W-1:0] RECIP =
    MUL_W'(((longint'(1) << SHIFT) + longint'(DIVISOR) - longint'(1)) / longint'(DIVISOR));

  logic [NUM_W-1:0]  num_q;
  logic [QUO_W-1:0]  quo_q;
  logic              busy_q;
  logic [PROD_W-1:0] prod;

  assign prod = PROD_W'(num_q) * PROD_W'(RECIP);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else begin
      busy_q <= start_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= dividend_i;
    end
    if (busy_q) begin
      quo_q <= prod[SHIFT +: QUO_W];
    end
  end

  assign done_o     = !busy_q;
  assign quotient_o = quo_q;

endmodule

### sv/pedal_adc_iir_window_stats.sv
// Pedal ADC conditioner: per-channel biquad IIR and moving-window statistics.
// Depends on paiws_pkg, paiws_ram (sample rings) and paiws_div (window average).
//
//   channel   direction  handshake                 payload
//   in        sink       in_valid_i / in_stall_o   channel_i, sample_i
//   out       source     out_valid_o / out_stall_i out_channel_o, filtered_o, window_*_o,
//                                                  buffers_valid_o
//   cfg       sink       cfg_we_i                  cfg_index_i, cfg_data_i
//
// After a request is taken the block reads the channel's rings, forms the products through
// one shared multiplier, writes back, scans the channel's filtered ring through its single
// read port while the average is formed, and loads the output; the next request is taken
// after that.
// A request for a channel that is not present goes straight to the output load.
// After reset a clearing pass fills all CHANNELS * WINDOW entries of both rings; no request
// is taken during it, configuration writes are.
// A finished result waits in the output register while the next request is taken.
module pedal_adc_iir_window_stats #(
  parameter int CHANNELS   = 8,
  parameter int WINDOW     = 16,
  parameter int OVERSAMPLE = 4
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic [paiws_pkg::CHAN_IN_W-1:0]    channel_i,
  input  logic [paiws_pkg::DATA_W-1:0]       sample_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic [paiws_pkg::CHAN_IN_W-1:0]    out_channel_o,
  output logic [paiws_pkg::DATA_W-1:0]       filtered_o,
  output logic [paiws_pkg::DATA_W-1:0]       window_average_o,
  output logic [paiws_pkg::DATA_W-1:0]       window_minimum_o,
  output logic [paiws_pkg::DATA_W-1:0]       window_maximum_o,
  output logic                               buffers_valid_o,
  input  logic                               cfg_we_i,
  input  logic [paiws_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [paiws_pkg::CFG_DATA_W-1:0]   cfg_data_i
);

  localparam int DW     = paiws_pkg::DATA_W;
  localparam int CIW    = paiws_pkg::CHAN_IN_W;
  localparam int ACC_W  = paiws_pkg::ACC_W;
  localparam int PROD_W = paiws_pkg::PROD_W;
  localparam int CH_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int POS_W  = $clog2(WINDOW);
  localparam int DEPTH  = CHANNELS * WINDOW;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int SUM_W  = DW + POS_W;
  localparam int CNT_W  = $clog2(2 * WINDOW + 1);
  localparam int STEP_W = POS_W + 2;

  localparam logic [DW-1:0]     RESET_LEVEL = DW'(paiws_pkg::RESET_BASE * OVERSAMPLE);
  localparam logic [SUM_W-1:0]  RESET_SUM   =
    SUM_W'(paiws_pkg::RESET_BASE * OVERSAMPLE * WINDOW);
  localparam logic [CNT_W-1:0]  FILL_INIT   = CNT_W'(2 * WINDOW);
  localparam logic [SUM_W-1:0]  SUM_MAX     = SUM_W'((2 ** DW - 1) * WINDOW);

  paiws_pkg::state_e state_q, state_d;
  logic [STEP_W-1:0] step_q, step_d;

  logic [paiws_pkg::MASK_W-1:0]            mask_q;
  logic signed [paiws_pkg::COEF_W-1:0]     coef_q [paiws_pkg::COEF_N];

  logic [POS_W-1:0]  wpos_q [CHANNELS];
  logic [SUM_W-1:0]  wsum_q [CHANNELS];
  logic [CNT_W-1:0]  fill_q [CHANNELS];

  logic [CIW-1:0]    ch_q;
  logic [DW-1:0]     x_q, x1_q, x2_q, y1_q, y2_q, old_q, y_q, min_q, max_q;
  logic              ok_q;
  logic [ADDR_W-1:0] clr_q;
  logic signed [PROD_W-1:0] prod_q;
  logic signed [ACC_W-1:0]  acc_q;

  logic              out_valid_q, out_bv_q;
  logic [CIW-1:0]    out_ch_q;
  logic [DW-1:0]     out_filt_q, out_avg_q, out_min_q, out_max_q;

  logic              in_ok;
  logic [CH_W-1:0]   ch_idx;
  logic [POS_W-1:0]  pos, p1, p2;
  logic [ADDR_W-1:0] base_addr;
  logic              raw_we, raw_re, flt_we, flt_re;
  logic [ADDR_W-1:0] raw_waddr, raw_raddr, flt_waddr, flt_raddr;
  logic [DW-1:0]     raw_wdata, flt_wdata, raw_rd, flt_rd;
  logic signed [paiws_pkg::COEF_W-1:0] mac_coef;
  logic [DW-1:0]     mac_opnd;
  logic [DW-1:0]     y_c;
  logic [SUM_W-1:0]  wsum_new;
  logic              div_done;
  logic [DW-1:0]     div_quo;
  logic              out_load;

  assign in_ok  = {2'b00, channel_i} < (CIW + 2)'(CHANNELS);
  assign ch_idx = CH_W'(ch_q);

  always_comb begin
    pos = (wpos_q[ch_idx] == '0) ? POS_W'(WINDOW - 1) : wpos_q[ch_idx] - POS_W'(1);
    p1  = (pos == POS_W'(WINDOW - 1)) ? '0 : pos + POS_W'(1);
    p2  = (p1 == POS_W'(WINDOW - 1)) ? '0 : p1 + POS_W'(1);
  end

  assign base_addr = ADDR_W'(ch_idx * WINDOW);

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q    <= '0;
      coef_q[0] <= paiws_pkg::B0_RST;
      coef_q[1] <= paiws_pkg::B1_RST;
      coef_q[2] <= paiws_pkg::B2_RST;
      coef_q[3] <= paiws_pkg::A1_RST;
      coef_q[4] <= paiws_pkg::A2_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        paiws_pkg::CFG_MASK: mask_q    <= cfg_data_i[paiws_pkg::MASK_W-1:0];
        paiws_pkg::CFG_B0:   coef_q[0] <= $signed(cfg_data_i);
        paiws_pkg::CFG_B1:   coef_q[1] <= $signed(cfg_data_i);
        paiws_pkg::CFG_B2:   coef_q[2] <= $signed(cfg_data_i);
        paiws_pkg::CFG_A1:   coef_q[3] <= $signed(cfg_data_i);
        paiws_pkg::CFG_A2:   coef_q[4] <= $signed(cfg_data_i);
        default: ;
      endcase
    end
  end

  // sequencer
  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    unique case (state_q)
      paiws_pkg::ST_CLEAR: begin
        if (clr_q == ADDR_W'(DEPTH - 1)) state_d = paiws_pkg::ST_IDLE;
      end
      paiws_pkg::ST_IDLE: begin
        step_d = '0;
        if (in_valid_i) state_d = in_ok ? paiws_pkg::ST_READ : paiws_pkg::ST_DONE;
      end
      paiws_pkg::ST_READ: begin
        step_d = step_q + STEP_W'(1);
        if (step_q == STEP_W'(3)) begin
          state_d = paiws_pkg::ST_MAC;
          step_d  = '0;
        end
      end
      paiws_pkg::ST_MAC: begin
        step_d = step_q + STEP_W'(1);
        if (step_q == STEP_W'(paiws_pkg::COEF_N)) begin
          state_d = paiws_pkg::ST_WRITE;
          step_d  = '0;
        end
      end
      paiws_pkg::ST_WRITE: begin
        state_d = paiws_pkg::ST_SCAN;
        step_d  = '0;
      end
      paiws_pkg::ST_SCAN: begin
        if (step_q <= STEP_W'(WINDOW)) begin
          step_d = step_q + STEP_W'(1);
        end else if (div_done) begin
          state_d = paiws_pkg::ST_DONE;
        end
      end
      paiws_pkg::ST_DONE: begin
        if (!out_valid_q || !out_stall_i) state_d = paiws_pkg::ST_IDLE;
      end
      default: state_d = paiws_pkg::ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= paiws_pkg::ST_CLEAR;
      step_q  <= '0;
      clr_q   <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
      if (state_q == paiws_pkg::ST_CLEAR) clr_q <= clr_q + ADDR_W'(1);
    end
  end

  assign in_stall_o = state_q != paiws_pkg::ST_IDLE;

  // ring ports
  always_comb begin
    raw_we    = 1'b0;
    raw_waddr = base_addr + ADDR_W'(pos);
    raw_wdata = x_q;
    raw_re    = 1'b0;
    raw_raddr = base_addr + ADDR_W'(p1);
    flt_we    = 1'b0;
    flt_waddr = base_addr + ADDR_W'(pos);
    flt_wdata = y_c;
    flt_re    = 1'b0;
    flt_raddr = base_addr + ADDR_W'(p1);
    unique case (state_q)
      paiws_pkg::ST_CLEAR: begin
        raw_we    = 1'b1;
        raw_waddr = clr_q;
        raw_wdata = RESET_LEVEL;
        flt_we    = 1'b1;
        flt_waddr = clr_q;
        flt_wdata = RESET_LEVEL;
      end
      paiws_pkg::ST_READ: begin
        raw_we = step_q == STEP_W'(0);
        raw_re = step_q < STEP_W'(2);
        flt_re = step_q < STEP_W'(3);
        if (step_q == STEP_W'(1)) begin
          raw_raddr = base_addr + ADDR_W'(p2);
          flt_raddr = base_addr + ADDR_W'(p2);
        end else if (step_q == STEP_W'(2)) begin
          flt_raddr = base_addr + ADDR_W'(pos);
        end
      end
      paiws_pkg::ST_WRITE: flt_we = 1'b1;
      paiws_pkg::ST_SCAN: begin
        flt_re    = step_q < STEP_W'(WINDOW);
        flt_raddr = base_addr + ADDR_W'(step_q[POS_W-1:0]);
      end
      default: ;
    endcase
  end

  paiws_ram #(.WIDTH(DW), .DEPTH(DEPTH)) u_raw_ring (
    .clk_i   (clk_i),
    .we_i    (raw_we),
    .waddr_i (raw_waddr),
    .wdata_i (raw_wdata),
    .re_i    (raw_re),
    .raddr_i (raw_raddr),
    .rdata_o (raw_rd)
  );

  paiws_ram #(.WIDTH(DW), .DEPTH(DEPTH)) u_flt_ring (
    .clk_i   (clk_i),
    .we_i    (flt_we),
    .waddr_i (flt_waddr),
    .wdata_i (flt_wdata),
    .re_i    (flt_re),
    .raddr_i (flt_raddr),
    .rdata_o (flt_rd)
  );

  // shared multiplier operands
  always_comb begin
    mac_coef = '0;
    mac_opnd = '0;
    unique case (step_q)
      STEP_W'(0): begin mac_coef = coef_q[0]; mac_opnd = x_q;  end
      STEP_W'(1): begin mac_coef = coef_q[1]; mac_opnd = x1_q; end
      STEP_W'(2): begin mac_coef = coef_q[2]; mac_opnd = x2_q; end
      STEP_W'(3): begin mac_coef = coef_q[3]; mac_opnd = y1_q; end
      STEP_W'(4): begin mac_coef = coef_q[4]; mac_opnd = y2_q; end
      default: ;
    endcase
  end

  always_comb begin
    if (!mask_q[ch_q]) begin
      y_c = x_q;
    end else if (acc_q[ACC_W-1]) begin
      y_c = '0;
    end else if (|acc_q[ACC_W-2:DW]) begin
      y_c = '1;
    end else begin
      y_c = acc_q[DW-1:0];
    end
  end

  assign wsum_new = wsum_q[ch_idx] - SUM_W'(old_q) + SUM_W'(y_c);

  paiws_div #(.NUM_W(SUM_W), .DIVISOR(WINDOW), .QUO_W(DW)) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (state_q == paiws_pkg::ST_WRITE),
    .dividend_i (wsum_new),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  // datapath
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      paiws_pkg::ST_IDLE: begin
        ch_q <= channel_i;
        x_q  <= sample_i;
        ok_q <= in_ok;
      end
      paiws_pkg::ST_READ: begin
        if (step_q == STEP_W'(1)) begin
          x1_q <= raw_rd;
          y1_q <= flt_rd;
        end else if (step_q == STEP_W'(2)) begin
          x2_q <= raw_rd;
          y2_q <= flt_rd;
        end else if (step_q == STEP_W'(3)) begin
          old_q <= flt_rd;
        end
      end
      paiws_pkg::ST_MAC: begin
        prod_q <= mac_coef * $signed({1'b0, mac_opnd});
        if (step_q == STEP_W'(0)) begin
          acc_q <= '0;
        end else begin
          acc_q <= acc_q + ACC_W'($signed(prod_q[PROD_W-1:paiws_pkg::Q_SHIFT]));
        end
      end
      paiws_pkg::ST_WRITE: y_q <= y_c;
      paiws_pkg::ST_SCAN: begin
        if (step_q == STEP_W'(1)) begin
          min_q <= flt_rd;
          max_q <= flt_rd;
        end else if (step_q >= STEP_W'(2) && step_q <= STEP_W'(WINDOW)) begin
          if (flt_rd < min_q) min_q <= flt_rd;
          if (flt_rd > max_q) max_q <= flt_rd;
        end
      end
      default: ;
    endcase
  end

  // per-channel position, sum and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int c = 0; c < CHANNELS; c++) begin
        wpos_q[c] <= '0;
        wsum_q[c] <= RESET_SUM;
        fill_q[c] <= FILL_INIT;
      end
    end else if (state_q == paiws_pkg::ST_WRITE) begin
      wpos_q[ch_idx] <= pos;
      wsum_q[ch_idx] <= wsum_new;
      if (fill_q[ch_idx] != '0) fill_q[ch_idx] <= fill_q[ch_idx] - CNT_W'(1);
    end
  end

  // output register
  assign out_load = (state_q == paiws_pkg::ST_DONE) && (!out_valid_q || !out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_ch_q   <= ch_q;
      out_filt_q <= ok_q ? y_q : '0;
      out_avg_q  <= ok_q ? div_quo : '0;
      out_min_q  <= ok_q ? min_q : '0;
      out_max_q  <= ok_q ? max_q : '0;
      out_bv_q   <= ok_q && (fill_q[ch_idx] == '0);
    end
  end

  assign out_valid_o      = out_valid_q;
  assign out_channel_o    = out_ch_q;
  assign filtered_o       = out_filt_q;
  assign window_average_o = out_avg_q;
  assign window_minimum_o = out_min_q;
  assign window_maximum_o = out_max_q;
  assign buffers_valid_o  = out_bv_q;

  a_scan_waits_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == paiws_pkg::ST_SCAN && state_d == paiws_pkg::ST_DONE) |-> div_done)
    else $error("scan finished before window average");

  a_sum_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == paiws_pkg::ST_WRITE) |-> wsum_new <= SUM_MAX)
    else $error("window sum out of range");

  a_result_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == paiws_pkg::ST_DONE))
    else $error("result raised outside completion");

  a_filtered_in_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (window_minimum_o <= filtered_o && filtered_o <= window_maximum_o))
    else $error("filtered value outside window extremes");

endmodule
